[hdl/pseudocolor_map_assert.svh]
// Assertion macros used by the pseudocolor map top level
`ifndef PSEUDOCOLOR_MAP_ASSERT_SVH
`define PSEUDOCOLOR_MAP_ASSERT_SVH

// same-cycle implication
`define PLM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pseudocolor_map check failed");

// next-cycle implication
`define PLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pseudocolor_map check failed");

`endif

[hdl/plm_pkg.sv]
// Shared constants, types and color table for the pseudocolor map
package plm_pkg;

    localparam int FRAC_BITS = 16;   // fraction bits of samples and range registers
    localparam int POS_BITS  = 16;   // fraction bits of the normalized position
    localparam int P_W       = 5;    // leading-one index width
    localparam int L2_W      = P_W + FRAC_BITS + 1;
    localparam logic [31:0] LOG10_2_Q32 = 32'd1292913987;

    typedef enum logic [7:0] {
        REG_RANGE_LOW  = 8'd0,
        REG_RANGE_HIGH = 8'd1,
        REG_LOG_SCALE  = 8'd2,
        REG_CYCLIC_MAP = 8'd3
    } t_cfg_reg;

    // item moving through the squaring cells
    typedef struct packed {
        logic                 valid;
        logic                 nonpos;
        logic signed [31:0]   s;
        logic [P_W-1:0]       p;
        logic [31:0]          m;
        logic [FRAC_BITS-1:0] fr;
    } t_sq;

    // item moving through the divider cells
    typedef struct packed {
        logic              valid;
        logic              empty;
        logic [31:0]       r;
        logic [POS_BITS:0] q;
    } t_div;

    typedef enum logic [2:0] {
        STOP_BLUE   = 3'd0,
        STOP_CYAN   = 3'd1,
        STOP_YELLOW = 3'd2,
        STOP_RED    = 3'd3,
        STOP_BLUE_END = 3'd4
    } t_stop;

    // {red, green, blue}
    function automatic logic [23:0] stop_color(logic [2:0] idx);
        logic [23:0] c;
        unique case (idx)
            STOP_BLUE:     c = 24'h0000ff;
            STOP_CYAN:     c = 24'h00ffff;
            STOP_YELLOW:   c = 24'hffff00;
            STOP_RED:      c = 24'hff0000;
            STOP_BLUE_END: c = 24'h0000ff;
            default:       c = 24'h0000ff;
        endcase
        return c;
    endfunction

endpackage

[hdl/plm_in_if.sv]
// Sample stream channel
interface plm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

[hdl/plm_out_if.sv]
// Pixel stream channel
interface plm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       range_empty;

    modport source (output valid, output red, output green, output blue,
                    output range_empty, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input range_empty, output ready);
endinterface

[hdl/pseudocolor_map.sv]
// Pseudocolor map top level: log, normalize and color pipeline
//
// Use: samples (signed Q16.16) enter on i_in, one RGB pixel per sample leaves on
// o_out with a range_empty flag. Registers are loaded through i_cfg_we/i_cfg_idx/
// i_cfg_data while no item is in flight: 0 range_low, 1 range_high, 2 log_scale,
// 3 cyclic_map; other indexes are dropped.
// Throughput: one item per cycle while o_out is not stalled. The chain holds the
// 16 squaring cells of the log2 unit and the 16 divider cells of the normalizer,
// plus six register stages around them.
// The whole chain advances together; when o_out holds an item that is not taken,
// every stage holds and i_in.ready drops in the same cycle.
// Reset empties the chain and loads range 0..1.0, linear, three-segment map.
module pseudocolor_map (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    plm_in_if.sink        i_in,
    plm_out_if.source     o_out
);
    localparam int NSQ = plm_pkg::FRAC_BITS;
    localparam int NDV = plm_pkg::POS_BITS;

    logic signed [31:0] r_lo, r_hi;
    logic               r_log, r_cyc;
    logic               en;
    logic               empty;
    logic [31:0]        den;

    // stage A: input register
    logic               r_a_valid;
    logic signed [31:0] r_a_s;
    // stage B: normalization into the squaring chain
    plm_pkg::t_sq       n_b, r_b;
    plm_pkg::t_sq       sq [NSQ+1];
    // stage C: scale by log10(2)
    logic                     r_c_valid, r_c_neg, r_c_nonpos;
    logic signed [31:0]       r_c_s;
    logic [plm_pkg::L2_W+31:0] r_c_prod;
    logic [plm_pkg::L2_W-1:0] l2u, mag;
    // stage D: rounded value
    logic                     r_d_valid;
    logic signed [31:0]       r_d_v, n_d_v;
    logic [plm_pkg::L2_W+31:0] rsum;
    logic [plm_pkg::L2_W-1:0] rmag;
    // stage E: clamp and first quotient bit
    logic signed [31:0]       vc;
    logic [31:0]              num;
    plm_pkg::t_div            n_e, r_e;
    plm_pkg::t_div            dv [NDV+1];

    logic       out_valid;
    logic [7:0] out_r, out_g, out_b;
    logic       out_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo  <= '0;
            r_hi  <= 32'sd65536;
            r_log <= 1'b0;
            r_cyc <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                plm_pkg::REG_RANGE_LOW:  r_lo  <= i_cfg_data;
                plm_pkg::REG_RANGE_HIGH: r_hi  <= i_cfg_data;
                plm_pkg::REG_LOG_SCALE:  r_log <= i_cfg_data[0];
                plm_pkg::REG_CYCLIC_MAP: r_cyc <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign en         = !out_valid || o_out.ready;
    assign i_in.ready = en;
    assign empty      = r_hi <= r_lo;
    assign den        = 32'(r_hi - r_lo);

    always_comb begin
        n_b        = '0;
        n_b.valid  = r_a_valid;
        n_b.s      = r_a_s;
        n_b.nonpos = r_a_s <= 32'sd0;
        for (int i = 0; i < 32; i++) begin
            if (r_a_s[i]) n_b.p = plm_pkg::P_W'(i);
        end
        n_b.m = 32'(r_a_s) << (5'd31 - n_b.p);
    end

    assign sq[0] = r_b;
    for (genvar g = 0; g < NSQ; g++) begin : g_sq
        plm_sq_cell u_sq (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_sq(sq[g]), .o_sq(sq[g+1])
        );
    end

    always_comb begin
        l2u = ((plm_pkg::L2_W'(sq[NSQ].p) - plm_pkg::L2_W'(plm_pkg::FRAC_BITS))
               << plm_pkg::FRAC_BITS) | plm_pkg::L2_W'(sq[NSQ].fr);
        mag = l2u[plm_pkg::L2_W-1] ? -l2u : l2u;
    end

    always_comb begin
        rsum  = r_c_prod + ((plm_pkg::L2_W+32)'(1) << 31);
        rmag  = rsum[plm_pkg::L2_W+31:32];
        if (!r_log) begin
            n_d_v = r_c_s;
        end else if (r_c_nonpos) begin
            n_d_v = r_lo;
        end else begin
            n_d_v = 32'($signed(r_c_neg ? -rmag : rmag));
        end
    end

    always_comb begin
        if (r_d_v < r_lo)      vc = r_lo;
        else if (r_d_v > r_hi) vc = r_hi;
        else                   vc = r_d_v;
        num       = 32'(vc - r_lo);
        n_e       = '0;
        n_e.valid = r_d_valid;
        n_e.empty = empty;
        n_e.q[0]  = num >= den;
        n_e.r     = (num >= den) ? num - den : num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b       <= '0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e       <= '0;
        end else if (en) begin
            r_a_valid <= i_in.valid;
            r_b       <= n_b;
            r_c_valid <= sq[NSQ].valid;
            r_d_valid <= r_c_valid;
            r_e       <= n_e;
        end
        if (en) begin
            r_a_s      <= i_in.sample_value;
            r_c_s      <= sq[NSQ].s;
            r_c_nonpos <= sq[NSQ].nonpos;
            r_c_neg    <= l2u[plm_pkg::L2_W-1];
            r_c_prod   <= (plm_pkg::L2_W+32)'(mag) * (plm_pkg::L2_W+32)'(plm_pkg::LOG10_2_Q32);
            r_d_v      <= n_d_v;
        end
    end

    assign dv[0] = r_e;
    for (genvar g = 0; g < NDV; g++) begin : g_dv
        plm_div_cell u_dv (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_den(den),
            .i_div(dv[g]), .o_div(dv[g+1])
        );
    end

    plm_color u_color (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_cyclic(r_cyc),
        .i_div(dv[NDV]), .o_valid(out_valid), .o_red(out_r), .o_green(out_g),
        .o_blue(out_b), .o_empty(out_empty)
    );

    assign o_out.valid       = out_valid;
    assign o_out.red         = out_r;
    assign o_out.green       = out_g;
    assign o_out.blue        = out_b;
    assign o_out.range_empty = out_empty;

`include "pseudocolor_map_assert.svh"

    `PLM_ASSERT_NOW(a_empty_blue, i_clk, i_rst_n, out_valid && out_empty, out_r == 8'd0 && out_g == 8'd0 && out_b == 8'd255)
    `PLM_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in.valid && i_in.ready, r_a_valid)
    `PLM_ASSERT_NEXT(a_stall_holds_tail, i_clk, i_rst_n, !en && dv[NDV].valid, dv[NDV].valid)
endmodule

[hdl/plm_sq_cell.sv]
// One log2 fraction bit per cell by squaring the mantissa
module plm_sq_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  plm_pkg::t_sq  i_sq,
    output plm_pkg::t_sq  o_sq
);
    plm_pkg::t_sq r_sq, n_sq;
    logic [63:0]  prod;
    logic [32:0]  m2;

    always_comb begin
        prod  = 64'(i_sq.m) * 64'(i_sq.m);
        m2    = prod[63:31];
        n_sq  = i_sq;
        n_sq.fr = {i_sq.fr[plm_pkg::FRAC_BITS-2:0], m2[32]};
        n_sq.m  = m2[32] ? m2[32:1] : m2[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq <= '0;
        end else if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;
endmodule

[hdl/plm_div_cell.sv]
// One quotient bit per cell, restoring division
module plm_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [31:0]   i_den,
    input  plm_pkg::t_div i_div,
    output plm_pkg::t_div o_div
);
    plm_pkg::t_div r_div, n_div;
    logic [32:0]   rs;
    logic          ge;

    always_comb begin
        rs    = {i_div.r, 1'b0};
        ge    = rs >= {1'b0, i_den};
        n_div = i_div;
        n_div.r = ge ? 32'(rs - {1'b0, i_den}) : rs[31:0];
        n_div.q = {i_div.q[plm_pkg::POS_BITS-1:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= '0;
        end else if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;
endmodule

[hdl/plm_color.sv]
// Segment select, channel interpolation and output register
module plm_color (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_cyclic,
    input  plm_pkg::t_div i_div,
    output logic          o_valid,
    output logic [7:0]    o_red,
    output logic [7:0]    o_green,
    output logic [7:0]    o_blue,
    output logic          o_empty
);
    logic        r_valid;
    logic [23:0] r_rgb, n_rgb;
    logic        r_empty;
    logic [17:0] pos;
    logic [2:0]  seg;
    logic [15:0] t;
    logic [23:0] ca, cb;

    function automatic logic [7:0] lerp(logic [7:0] a, logic [7:0] b, logic [15:0] tt);
        logic [16:0] u;
        logic [24:0] pa, pb;
        u  = 17'h10000 - 17'(tt);
        pa = 25'(a) * 25'(u);
        pb = 25'(b) * 25'(tt);
        return 8'((pa + pb) >> 16);
    endfunction

    always_comb begin
        pos = i_cyclic ? {i_div.q[15:0], 2'b00} : 18'({i_div.q[15:0], 1'b0}) + 18'(i_div.q[15:0]);
        seg = {1'b0, pos[17:16]};
        t   = pos[15:0];
        ca  = plm_pkg::stop_color(seg);
        cb  = plm_pkg::stop_color(seg + 3'd1);
        if (i_div.empty) begin
            n_rgb = plm_pkg::stop_color(plm_pkg::STOP_BLUE);
        end else if (i_div.q[plm_pkg::POS_BITS]) begin
            // top of range: end color
            n_rgb = plm_pkg::stop_color(i_cyclic ? plm_pkg::STOP_BLUE_END : plm_pkg::STOP_RED);
        end else begin
            n_rgb = {lerp(ca[23:16], cb[23:16], t), lerp(ca[15:8], cb[15:8], t),
                     lerp(ca[7:0], cb[7:0], t)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_div.valid;
        end
        if (i_en) begin
            r_rgb   <= n_rgb;
            r_empty <= i_div.empty;
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_rgb[23:16];
    assign o_green = r_rgb[15:8];
    assign o_blue  = r_rgb[7:0];
    assign o_empty = r_empty;
endmodule
